// ===== rtl/websocket_frame_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on clk and arst_n being visible in the module that uses them.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define WSDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WSDF_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`else
`define WSDF_ASSERT(label, prop, msg)
`define WSDF_ASSERT_NEXT(label, cause, effect, msg)
`endif
`endif

// ===== rtl/wsdf_pkg.sv =====
// Types and codes for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer.
package wsdf_pkg;

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASK    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} wsdf_phase_t;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_RSV      = 3'd1;
	localparam logic [2:0] ERR_UNMASKED = 3'd2;
	localparam logic [2:0] ERR_FRAG     = 3'd3;
	localparam logic [2:0] ERR_BINARY   = 3'd4;
	localparam logic [2:0] ERR_CONT     = 3'd5;
	localparam logic [2:0] ERR_OPCODE   = 3'd6;
	localparam logic [2:0] ERR_TOO_BIG  = 3'd7;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

	localparam int unsigned REQ_RESTART = 1;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket client frame deframer. Input beats carry one stream byte or a restart
// request; output beats carry one unmasked payload byte, an empty-frame marker or an
// error. Configuration beats write the largest accepted payload length.
// The input register takes an accepted beat and the result register loads from it when
// it is free or being drained. Throughput: one input beat per cycle unless out_ready stalls.
// Each beat passes through one short parse step between the input register and the
// result register; the only wide logic is the 64-bit length shift and compare and the
// 64-bit remaining-byte down counter. Restarts and header bytes produce no output beat,
// except the error or empty-frame beat on the last header byte. An error produces one
// beat and then every stream byte is dropped until a restart beat arrives.
// Reset: clears all frame state, the error flag and both pipeline stages, and loads
// max payload with 1048576. The configuration channel is always ready; it should be
// written only while no accepted beat is still in flight.
// Stall: while out_ready is low a valid result beat holds; the input register still
// fills, so in_ready falls only when both stages are full.
// Depends on wsdf_pkg and websocket_frame_deframer_defines.svh.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer
	import wsdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [3:0]  frame_opcode,
	output logic        last,
	output logic [2:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] max_payload_q;

	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  data_s1;
	logic        advance;

	wsdf_phase_t phase_q, phase_d;
	logic [7:0]  fhb_q, fhb_d;
	logic [63:0] len_q, len_d, len_work;
	logic [3:0]  left_q, left_d;
	logic [31:0] key_q, key_d;
	logic [63:0] remain_q, remain_d;
	logic [1:0]  pos_q, pos_d;
	logic        mask_q, mask_d;
	logic        failed_q, failed_d;

	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic        res_last;
	logic [2:0]  res_err;
	logic        after_len;
	logic        hdr_done;
	logic        clr;
	logic [2:0]  hdr_err;
	logic [7:0]  key_byte;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [3:0]  opcode_q;
	logic        last_q;
	logic [2:0]  err_q;

	function automatic logic [2:0] header_error(input logic [7:0] fhb, input logic mbit,
			input logic [63:0] len, input logic [31:0] maxp);
		logic [3:0] op;
		op = fhb[3:0];
		if (fhb[6:4] != 3'd0)
			return ERR_RSV;
		if (!mbit)
			return ERR_UNMASKED;
		if (!fhb[7])
			return ERR_FRAG;
		if (op == OP_BINARY)
			return ERR_BINARY;
		if (op == OP_CONT)
			return ERR_CONT;
		if (op != OP_TEXT && op != OP_CLOSE && op != OP_PING && op != OP_PONG)
			return ERR_OPCODE;
		if ((|len[63:32]) || (len[31:0] > maxp))
			return ERR_TOO_BIG;
		return ERR_NONE;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// The input stage moves on whenever the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			data_s1     <= data_byte;
		end
	end

	always_comb begin
		unique case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		fhb_d     = fhb_q;
		len_d     = len_q;
		len_work  = len_q;
		left_d    = left_q;
		key_d     = key_q;
		remain_d  = remain_q;
		pos_d     = pos_q;
		mask_d    = mask_q;
		failed_d  = failed_q;
		res_valid = 1'b0;
		res_kind  = KIND_PAYLOAD;
		res_byte  = 8'd0;
		res_last  = 1'b0;
		res_err   = ERR_NONE;
		after_len = 1'b0;
		hdr_done  = 1'b0;
		clr       = 1'b0;
		hdr_err   = ERR_NONE;

		if (req_type_s1 == 1'(REQ_RESTART)) begin
			clr      = 1'b1;
			failed_d = 1'b0;
		end else if (!failed_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					fhb_d   = data_s1;
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					mask_d = data_s1[7];
					len_d  = 64'd0;
					if (data_s1[6:0] == LEN_EXT16) begin
						left_d  = EXT16_BYTES;
						phase_d = PH_EXTLEN;
					end else if (data_s1[6:0] == LEN_EXT64) begin
						left_d  = EXT64_BYTES;
						phase_d = PH_EXTLEN;
					end else begin
						len_work  = {57'd0, data_s1[6:0]};
						len_d     = len_work;
						after_len = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_work = {len_q[55:0], data_s1};
					len_d    = len_work;
					left_d   = left_q - 4'd1;
					if (left_q == 4'd1)
						after_len = 1'b1;
				end
				PH_MASK: begin
					key_d  = {key_q[23:0], data_s1};
					left_d = left_q - 4'd1;
					if (left_q == 4'd1)
						hdr_done = 1'b1;
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					res_byte  = data_s1 ^ key_byte;
					remain_d  = remain_q - 64'd1;
					pos_d     = pos_q + 2'd1;
					if (remain_q == 64'd1) begin
						res_last = 1'b1;
						clr      = 1'b1;
					end
				end
				default: begin
					clr = 1'b1;
				end
			endcase

			// Without a mask bit there is no key, so the header ends with the length.
			if (after_len) begin
				if (mask_d) begin
					phase_d = PH_MASK;
					left_d  = KEY_BYTES;
				end else begin
					hdr_done = 1'b1;
				end
			end

			if (hdr_done) begin
				hdr_err = header_error(fhb_d, mask_d, len_work, max_payload_q);
				if (hdr_err != ERR_NONE) begin
					failed_d  = 1'b1;
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_last  = 1'b1;
					res_err   = hdr_err;
				end else if (len_work == 64'd0) begin
					res_valid = 1'b1;
					res_kind  = KIND_EMPTY;
					res_last  = 1'b1;
					clr       = 1'b1;
				end else begin
					phase_d  = PH_PAYLOAD;
					remain_d = len_work;
					pos_d    = 2'd0;
				end
			end
		end

		if (clr) begin
			phase_d  = PH_HDR0;
			fhb_d    = 8'd0;
			len_d    = 64'd0;
			left_d   = 4'd0;
			key_d    = 32'd0;
			remain_d = 64'd0;
			pos_d    = 2'd0;
			mask_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fhb_q    <= 8'd0;
			len_q    <= 64'd0;
			left_q   <= 4'd0;
			key_q    <= 32'd0;
			remain_q <= 64'd0;
			pos_q    <= 2'd0;
			mask_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			fhb_q    <= fhb_d;
			len_q    <= len_d;
			left_q   <= left_d;
			key_q    <= key_d;
			remain_q <= remain_d;
			pos_q    <= pos_d;
			mask_q   <= mask_d;
			failed_q <= failed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q   <= res_kind;
			byte_q   <= res_byte;
			opcode_q <= fhb_q[3:0];
			last_q   <= res_last;
			err_q    <= res_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign out_byte     = byte_q;
	assign frame_opcode = opcode_q;
	assign last         = last_q;
	assign error_code   = err_q;

	`WSDF_ASSERT(a_err_beat_shape,
		(out_valid_q && kind_q == KIND_ERROR) |-> (last_q && err_q != ERR_NONE),
		"error beat without last or code")
	`WSDF_ASSERT_NEXT(a_err_sets_failed,
		advance && res_valid && res_kind == KIND_ERROR, failed_q,
		"error did not latch failed")
	`WSDF_ASSERT(a_failed_silent, failed_q |-> !res_valid, "result produced while failed")
	`WSDF_ASSERT(a_payload_count, (phase_q == PH_PAYLOAD) |-> (remain_q != 64'd0),
		"payload phase with no bytes left")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for websocket_frame_deframer: a short stimulus table, then random
// frame streams under several max_payload settings, all checked beat by beat.
// Depends on wsdf_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module tb;
	import wsdf_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload;
		logic [3:0] opcode;
		logic       last;
		logic [2:0] err;
	} deframed_beat_t;

	typedef struct packed {
		logic           restart;
		logic [7:0]     octet;
		logic           pinned;
		deframed_beat_t result;
	} script_row_t;

	localparam deframed_beat_t NO_BEAT = '0;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned PHASE_COUNT = 6;
	localparam int unsigned ITEMS_PER_PHASE = 325;

	// Unmasked frame, sticky error, empty ping, then a 64-bit length of all ones.
	localparam script_row_t DIRECTED_ROWS [25] = '{
		'{1'b1, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'h81, 1'b0, NO_BEAT},
		'{1'b0, 8'h05, 1'b1, '{KIND_ERROR, 8'h00, OP_TEXT, 1'b1, ERR_UNMASKED}},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b1, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'h89, 1'b0, NO_BEAT},
		'{1'b0, 8'h80, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b1, '{KIND_EMPTY, 8'h00, OP_PING, 1'b1, ERR_NONE}},
		'{1'b0, 8'h81, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'hFF, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b0, NO_BEAT},
		'{1'b0, 8'h00, 1'b1, '{KIND_ERROR, 8'h00, OP_TEXT, 1'b1, ERR_TOO_BIG}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [3:0]  frame_opcode;
	logic        last;
	logic [2:0]  error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'h0;

	websocket_frame_deframer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.out_byte     (out_byte),
		.frame_opcode (frame_opcode),
		.last         (last),
		.error_code   (error_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted deframer state.
	wsdf_phase_t parse_phase = PH_HDR0;
	logic [7:0]  first_hdr = '0;
	logic [63:0] frame_len = '0;
	logic [3:0]  len_bytes_left = '0;
	logic [31:0] mask_key = '0;
	logic [63:0] pay_pos = '0;
	logic        mask_on = 1'b0;
	logic        stream_failed = 1'b0;
	logic [31:0] max_len = MAX_PAYLOAD_RESET;

	deframed_beat_t expected_beats [$];
	int unsigned    mismatches = 0;
	int unsigned    items_done = 0;
	int unsigned    idle_cycles = 0;
	int unsigned    hold_left = 0;
	bit             gap_on = 1'b1;
	bit             stall_on = 1'b1;

	function automatic void clear_frame();
		parse_phase = PH_HDR0;
		first_hdr = '0;
		frame_len = '0;
		len_bytes_left = '0;
		mask_key = '0;
		pay_pos = '0;
		mask_on = 1'b0;
	endfunction

	function automatic logic [2:0] header_fault();
		logic [3:0] op;
		op = first_hdr[3:0];
		if (first_hdr[6:4] != 3'b000) return ERR_RSV;
		if (!mask_on) return ERR_UNMASKED;
		if (!first_hdr[7]) return ERR_FRAG;
		if (op == OP_BINARY) return ERR_BINARY;
		if (op == OP_CONT) return ERR_CONT;
		if (op != OP_TEXT && op != OP_CLOSE && op != OP_PING && op != OP_PONG)
			return ERR_OPCODE;
		if (frame_len > {32'd0, max_len}) return ERR_TOO_BIG;
		return ERR_NONE;
	endfunction

	function automatic bit header_done(output deframed_beat_t beat);
		logic [2:0] err;
		err = header_fault();
		beat = NO_BEAT;
		if (err != ERR_NONE) begin
			stream_failed = 1'b1;
			beat = '{KIND_ERROR, 8'h00, first_hdr[3:0], 1'b1, err};
			return 1'b1;
		end
		if (frame_len == 0) begin
			beat = '{KIND_EMPTY, 8'h00, first_hdr[3:0], 1'b1, ERR_NONE};
			clear_frame();
			return 1'b1;
		end
		parse_phase = PH_PAYLOAD;
		pay_pos = '0;
		return 1'b0;
	endfunction

	// Without a mask bit there is no key, so the header ends with the length.
	function automatic bit length_done(output deframed_beat_t beat);
		beat = NO_BEAT;
		if (mask_on) begin
			parse_phase = PH_MASK;
			len_bytes_left = KEY_BYTES;
			return 1'b0;
		end
		return header_done(beat);
	endfunction

	function automatic bit deframe_step(input logic restart, input logic [7:0] octet,
			output deframed_beat_t beat);
		logic [7:0] k;
		beat = NO_BEAT;
		if (restart) begin
			stream_failed = 1'b0;
			clear_frame();
			return 1'b0;
		end
		if (stream_failed) return 1'b0;
		case (parse_phase)
			PH_HDR0: begin
				first_hdr = octet;
				parse_phase = PH_HDR1;
				return 1'b0;
			end
			PH_HDR1: begin
				mask_on = octet[7];
				frame_len = '0;
				if (octet[6:0] == LEN_EXT16) begin
					len_bytes_left = EXT16_BYTES;
					parse_phase = PH_EXTLEN;
					return 1'b0;
				end
				if (octet[6:0] == LEN_EXT64) begin
					len_bytes_left = EXT64_BYTES;
					parse_phase = PH_EXTLEN;
					return 1'b0;
				end
				frame_len = {57'd0, octet[6:0]};
				return length_done(beat);
			end
			PH_EXTLEN: begin
				frame_len = {frame_len[55:0], octet};
				len_bytes_left = len_bytes_left - 4'd1;
				if (len_bytes_left != 0) return 1'b0;
				return length_done(beat);
			end
			PH_MASK: begin
				mask_key = {mask_key[23:0], octet};
				len_bytes_left = len_bytes_left - 4'd1;
				if (len_bytes_left != 0) return 1'b0;
				return header_done(beat);
			end
			PH_PAYLOAD: begin
				// The first key byte sits in the top of the key word.
				k = 8'(mask_key >> (8 * (3 - int'(pay_pos[1:0]))));
				pay_pos = pay_pos + 64'd1;
				beat = '{KIND_PAYLOAD, octet ^ k, first_hdr[3:0], 1'b0, ERR_NONE};
				if (pay_pos >= frame_len) begin
					beat.last = 1'b1;
					clear_frame();
				end
				return 1'b1;
			end
			default: begin
				clear_frame();
				return 1'b0;
			end
		endcase
	endfunction

	task automatic send_beat(input logic restart, input logic [7:0] octet, input logic pinned,
			input deframed_beat_t pinned_beat);
		deframed_beat_t beat;
		bit produced;
		bit counted;
		if (gap_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= restart;
		data_byte <= octet;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		counted = restart || !stream_failed;
		produced = deframe_step(restart, octet, beat);
		if (pinned) expected_beats.push_back(pinned_beat);
		else if (produced) expected_beats.push_back(beat);
		if (counted) items_done++;
	endtask

	// A stray restart now and then lands in whatever parse phase is current.
	task automatic feed(input logic [7:0] octet);
		if ($urandom_range(0, 199) == 0) send_beat(1'b1, 8'($urandom), 1'b0, NO_BEAT);
		send_beat(1'b0, octet, 1'b0, NO_BEAT);
	endtask

	task automatic send_frame();
		logic [7:0]  hdr0;
		logic [63:0] span;
		logic [31:0] key;
		logic        mask;
		int unsigned pick;
		int unsigned form;
		int unsigned n;
		int unsigned v;
		if (stream_failed || parse_phase != PH_HDR0)
			send_beat(1'b1, 8'($urandom), 1'b0, NO_BEAT);
		case ($urandom_range(0, 3))
			0: hdr0 = {1'b1, 3'b000, OP_TEXT};
			1: hdr0 = {1'b1, 3'b000, OP_CLOSE};
			2: hdr0 = {1'b1, 3'b000, OP_PING};
			default: hdr0 = {1'b1, 3'b000, OP_PONG};
		endcase
		pick = $urandom_range(0, 99);
		if (pick >= 70 && pick < 78) begin
			hdr0 = 8'($urandom);
		end else if (pick >= 78) begin
			case ($urandom_range(0, 4))
				0: hdr0[6:4] = 3'($urandom_range(1, 7));
				1: hdr0[7] = 1'b0;
				2: hdr0[3:0] = OP_BINARY;
				3: hdr0[3:0] = OP_CONT;
				default: begin
					v = $urandom_range(0, 9);
					hdr0[3:0] = 4'((v < 5) ? v + 3 : v + 6);
				end
			endcase
		end
		mask = ($urandom_range(0, 14) != 0);
		feed(hdr0);
		form = $urandom_range(0, 99);
		if (form < 60) begin
			span = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 125))
				: 64'($urandom_range(0, 20));
			if (max_len < 126 && $urandom_range(0, 3) == 0)
				span = {32'd0, max_len} + 64'($urandom_range(0, 1));
			if (span > 125) span = 64'd125;
			feed({mask, span[6:0]});
		end else if (form < 85) begin
			span = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 65535))
				: 64'($urandom_range(0, 40));
			feed({mask, LEN_EXT16});
			feed(span[15:8]);
			feed(span[7:0]);
		end else begin
			case ($urandom_range(0, 3))
				0: span = {$urandom, $urandom};
				1: span = {32'd0, max_len} + 64'($urandom_range(0, 1));
				default: span = 64'($urandom_range(0, 40));
			endcase
			feed({mask, LEN_EXT64});
			for (int i = 7; i >= 0; i--) feed(span[8 * i +: 8]);
		end
		if (mask) begin
			key = $urandom;
			for (int i = 3; i >= 0; i--) feed(key[8 * i +: 8]);
		end
		if (stream_failed) begin
			repeat ($urandom_range(0, 3)) feed(8'($urandom));
			return;
		end
		if (parse_phase == PH_HDR0) return;
		n = (span > 48) ? $urandom_range(0, 48) : int'(span);
		if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
		repeat (n) feed(8'($urandom));
	endtask

	// Header bytes in flight give no beat, so let the pipeline drain before the write.
	task automatic write_max_payload(input logic [31:0] value);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		max_len = value;
	endtask

	task automatic check_beat(input deframed_beat_t want);
		if (kind !== want.kind) begin
			$error("kind: expected %0d, actual %0d", want.kind, kind);
			mismatches++;
		end
		if (out_byte !== want.payload) begin
			$error("out_byte: expected 0x%02h, actual 0x%02h", want.payload, out_byte);
			mismatches++;
		end
		if (frame_opcode !== want.opcode) begin
			$error("frame_opcode: expected %0d, actual %0d", want.opcode, frame_opcode);
			mismatches++;
		end
		if (last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, last);
			mismatches++;
		end
		if (error_code !== want.err) begin
			$error("error_code: expected %0d, actual %0d", want.err, error_code);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("output beat with nothing expected: kind %0d, out_byte 0x%02h",
					kind, out_byte);
				mismatches++;
			end else begin
				check_beat(expected_beats.pop_front());
			end
		end
	end

	// The receiver drops out_ready in random bursts while stall_on is set.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			hold_left <= $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_beat(DIRECTED_ROWS[i].restart, DIRECTED_ROWS[i].octet,
				DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].result);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p == PHASE_COUNT - 1) begin
				gap_on = 1'b0;
				stall_on = 1'b0;
			end else begin
				gap_on = (p == 0) || ($urandom_range(0, 3) != 0);
				stall_on = (p == 0) || ($urandom_range(0, 3) != 0);
			end
			case (p)
				0: write_max_payload(32'hFFFF_FFFF);
				1: write_max_payload(32'd0);
				2: write_max_payload(32'd20);
				3: write_max_payload(32'($urandom_range(1, 60)));
				4: write_max_payload(MAX_PAYLOAD_RESET);
				default: write_max_payload(32'hFFFF_FFFF);
			endcase
			while (items_done < (p + 1) * ITEMS_PER_PHASE) send_frame();
		end

		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
